[sv/tmiw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tmiw_pkg;

  localparam int MOM_W      = 26;
  localparam int Q_W        = 2;
  localparam int PM_W       = 20;
  localparam int WIN_W      = 23;
  localparam int MASS_W     = 23;
  localparam int SLOT_OUT_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 23;
  localparam int E_W        = 27;
  localparam int ES_W       = 28;
  localparam int OP_W       = 28;
  localparam int SQ_W       = 56;
  localparam int ROOT_W     = 28;
  localparam int REM_W      = 30;

  localparam int DEF_MAX_TRACKS = 16;

  localparam logic [PM_W-1:0]  PION_MASS_RST   = 20'd139570;
  localparam logic [PM_W-1:0]  KAON_MASS_RST   = 20'd493680;
  localparam logic [WIN_W-1:0] WINDOW_LOW_RST  = 23'd1700000;
  localparam logic [WIN_W-1:0] WINDOW_HIGH_RST = 23'd2100000;

  localparam logic [CFG_IDX_W-1:0] REG_PION_MASS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KAON_MASS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd3;

  localparam logic [Q_W-1:0] Q_NEG = 2'b11;
  localparam logic [Q_W-1:0] Q_POS = 2'b01;

  typedef struct packed {
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
    logic [Q_W-1:0]          q;
  } track_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_READ,
    ST_CHECK,
    ST_HYP,
    ST_EMIT,
    ST_FLUSH,
    ST_STORE
  } state_t;

  typedef enum logic [2:0] {
    PH_P2N,
    PH_EN_PI,
    PH_EN_K,
    PH_P2E,
    PH_EE_PI,
    PH_EE_K,
    PH_PS2,
    PH_M2
  } phase_t;

endpackage

`default_nettype wire

[sv/tmiw_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tmiw_track_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tmiw_pkg::MOM_W-1:0]    mom_x;
  logic signed [tmiw_pkg::MOM_W-1:0]    mom_y;
  logic signed [tmiw_pkg::MOM_W-1:0]    mom_z;
  logic signed [tmiw_pkg::Q_W-1:0]      track_charge;
  logic                                 event_end;

  modport source (output valid, mom_x, mom_y, mom_z, track_charge, event_end, input ready);
  modport sink (input valid, mom_x, mom_y, mom_z, track_charge, event_end, output ready);
endinterface

interface tmiw_result_if;
  logic                                valid;
  logic                                ready;
  logic [tmiw_pkg::MASS_W-1:0]         pair_mass;
  logic                                hypothesis;
  logic [tmiw_pkg::SLOT_OUT_W-1:0]     partner_slot;
  logic                                last_result;

  modport source (output valid, pair_mass, hypothesis, partner_slot, last_result, input ready);
  modport sink (input valid, pair_mass, hypothesis, partner_slot, last_result, output ready);
endinterface

`default_nettype wire

[sv/two_track_invariant_mass_window_core.sv]
// Two-track invariant mass window, kaon-pion pairs.
// Tracks arrive on the tracks channel (valid/ready), one item per track, with
// event_end set on the last track of an event. Each track is paired with the
// stored earlier tracks of another charge; both hypotheses are evaluated and
// masses inside [window_low, window_high] leave on the results channel, in
// slot order, hypothesis 0 first, last_result marking the final one per track.
// Configuration is a write port (cfg_wr_en, cfg_index, cfg_data), to be written
// idle by the user; the block itself does not enforce this. Processing time is
// set by the one shared 28-step square-root unit, used twice per track and up
// to four times per opposite-charge pair; same-charge tracks are skipped.
// The next track is taken once the current one is stored.
// Each result is held back until the next one is found or the track is done,
// so that the last one can be marked.
// A stalled receiver holds the output register; the sequencer waits when it
// has a new result and both holding registers are full.
// Reset restores the register defaults and empties the track store; store
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module two_track_invariant_mass_window_core #(
  parameter int MAX_TRACKS = tmiw_pkg::DEF_MAX_TRACKS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tmiw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmiw_pkg::CFG_W-1:0]     cfg_data,
  tmiw_track_if.sink                     tracks,
  tmiw_result_if.source                  results
);
  import tmiw_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_TRACKS);
  localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
  localparam int MAX_RES = 2 * (MAX_TRACKS - 1);
  localparam int RES_W   = $clog2(MAX_RES + 1);

  function automatic logic [OP_W-1:0] mag(input logic signed [OP_W-1:0] v);
    return v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
  endfunction

  logic [PM_W-1:0]  pion_mass;
  logic [PM_W-1:0]  kaon_mass;
  logic [WIN_W-1:0] window_low;
  logic [WIN_W-1:0] window_high;

  state_t state, state_next;
  phase_t phase;
  logic [1:0]        k;
  logic [SQ_W-1:0]   acc;
  logic [SQ_W-1:0]   sq_q;
  logic [SQ_W-1:0]   sum;
  logic [SQ_W-1:0]   p2n, p2e, ps2;
  logic [E_W-1:0]    en_pi, en_k, ee_pi, ee_k;
  logic [ES_W-1:0]   es;
  logic [ROOT_W-1:0] mass;
  track_t            trk, ent, rdata;
  logic              ev_end;
  logic [CNT_W-1:0]  s, count;
  logic [CNT_W+3:0]  s_ext;
  logic [RES_W-1:0]  n;
  logic              h;

  logic                  pend_valid;
  logic [MASS_W-1:0]     pend_mass;
  logic                  pend_hyp;
  logic [SLOT_OUT_W-1:0] pend_slot;

  logic                  out_valid;
  logic [MASS_W-1:0]     out_mass;
  logic                  out_hyp;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_last;

  track_t mem [MAX_TRACKS];

  root_req_t root_req;
  root_rsp_t root_rsp;

  logic [1:0]            nops;
  logic                  last_k;
  logic signed [OP_W-1:0] tc, ec;
  logic [OP_W-1:0]       op;
  logic [2*OP_W-1:0]     prod;
  logic                  m2_neg, in_win, ekaon, hyp_full, more, q_same, ofree, cnt_room;
  logic [E_W-1:0]        ea, eb;
  logic                  in_take, rd_en, mem_we, push, emit_go, flush_go;

  tmiw_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pion_mass   <= PION_MASS_RST;
      kaon_mass   <= KAON_MASS_RST;
      window_low  <= WINDOW_LOW_RST;
      window_high <= WINDOW_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PION_MASS:   pion_mass   <= cfg_data[PM_W-1:0];
        REG_KAON_MASS:   kaon_mass   <= cfg_data[PM_W-1:0];
        REG_WINDOW_LOW:  window_low  <= cfg_data[WIN_W-1:0];
        REG_WINDOW_HIGH: window_high <= cfg_data[WIN_W-1:0];
      endcase
    end
  end

  // operand select for the shared squarer
  always_comb begin
    unique case (k)
      2'd0:    begin tc = {{2{trk.mom_x[MOM_W-1]}}, trk.mom_x};
                     ec = {{2{ent.mom_x[MOM_W-1]}}, ent.mom_x}; end
      2'd1:    begin tc = {{2{trk.mom_y[MOM_W-1]}}, trk.mom_y};
                     ec = {{2{ent.mom_y[MOM_W-1]}}, ent.mom_y}; end
      default: begin tc = {{2{trk.mom_z[MOM_W-1]}}, trk.mom_z};
                     ec = {{2{ent.mom_z[MOM_W-1]}}, ent.mom_z}; end
    endcase
    unique case (phase)
      PH_P2N:             begin op = mag(tc);              nops = 2'd3; end
      PH_P2E:             begin op = mag(ec);              nops = 2'd3; end
      PH_PS2:             begin op = mag(tc + ec);         nops = 2'd3; end
      PH_EN_PI, PH_EE_PI: begin op = OP_W'(pion_mass);     nops = 2'd1; end
      PH_EN_K, PH_EE_K:   begin op = OP_W'(kaon_mass);     nops = 2'd1; end
      PH_M2:              begin op = OP_W'(es);            nops = 2'd1; end
    endcase
  end

  assign prod     = op * op;
  assign last_k   = (k == nops);
  assign sum      = acc + sq_q;
  assign m2_neg   = (sum < ps2);
  assign in_win   = (mass >= ROOT_W'(window_low)) && (mass <= ROOT_W'(window_high));
  assign ekaon    = h ? (ent.q == Q_POS) : (ent.q == Q_NEG);
  assign ea       = ekaon ? ee_k : ee_pi;
  assign eb       = ekaon ? en_pi : en_k;
  assign hyp_full = (n >= RES_W'(MAX_RES));
  assign more     = (s < count);
  assign q_same   = (rdata.q == trk.q);
  assign ofree    = !out_valid || results.ready;
  assign cnt_room = (count < CNT_W'(MAX_TRACKS));
  assign in_take  = tracks.valid && tracks.ready;
  assign s_ext    = {4'b0000, s};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take) state_next = ST_SQ;
      ST_SQ: begin
        if (last_k) begin
          unique case (phase)
            PH_P2N, PH_P2E: state_next = ST_SQ;
            PH_PS2:         state_next = ST_HYP;
            PH_M2:          state_next = m2_neg ? (h ? ST_READ : ST_HYP) : ST_ROOT;
            default:        state_next = ST_ROOT;
          endcase
        end
      end
      ST_ROOT: begin
        if (root_rsp.done) begin
          unique case (phase)
            PH_EN_K: state_next = ST_READ;
            PH_M2:   state_next = ST_EMIT;
            default: state_next = ST_SQ;
          endcase
        end
      end
      ST_READ:  state_next = more ? ST_CHECK : ST_FLUSH;
      ST_CHECK: state_next = q_same ? ST_READ : ST_SQ;
      ST_HYP:   state_next = hyp_full ? ST_FLUSH : ST_SQ;
      ST_EMIT:  if (emit_go) state_next = h ? ST_READ : ST_HYP;
      ST_FLUSH: if (flush_go) state_next = ST_STORE;
      ST_STORE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tracks.ready      = 1'b0;
    root_req.start    = 1'b0;
    root_req.radicand = sum;
    rd_en             = 1'b0;
    mem_we            = 1'b0;
    emit_go           = 1'b0;
    flush_go          = 1'b0;
    push              = 1'b0;
    unique case (state)
      ST_IDLE: tracks.ready = 1'b1;
      ST_SQ: begin
        if (last_k) begin
          unique case (phase)
            PH_EN_PI, PH_EN_K, PH_EE_PI, PH_EE_K: root_req.start = 1'b1;
            PH_M2: begin
              root_req.start    = !m2_neg;
              root_req.radicand = sum - ps2;
            end
            default: ;
          endcase
        end
      end
      ST_READ:  rd_en = more;
      ST_EMIT: begin
        emit_go = !(in_win && pend_valid && !ofree);
        push    = in_win && pend_valid && ofree;
      end
      ST_FLUSH: begin
        flush_go = !pend_valid || ofree;
        push     = pend_valid && ofree;
      end
      ST_STORE: mem_we = cnt_room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[SLOT_W-1:0]] <= trk;
    if (rd_en) rdata <= mem[s[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_STORE) begin
        if (ev_end) count <= '0;
        else if (cnt_room) count <= count + CNT_W'(1);
      end
      if (emit_go && in_win) pend_valid <= 1'b1;
      else if (flush_go) pend_valid <= 1'b0;
      if (push) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_mass <= pend_mass;
      out_hyp  <= pend_hyp;
      out_slot <= pend_slot;
      out_last <= (state == ST_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          trk.mom_x <= tracks.mom_x;
          trk.mom_y <= tracks.mom_y;
          trk.mom_z <= tracks.mom_z;
          trk.q     <= tracks.track_charge;
          ev_end    <= tracks.event_end;
          phase     <= PH_P2N;
          k         <= 2'd0;
          acc       <= '0;
          n         <= '0;
          h         <= 1'b0;
        end
      end
      ST_SQ: begin
        sq_q <= prod;
        if (!last_k) begin
          k <= k + 2'd1;
          if (k != 2'd0) acc <= sum;
        end else begin
          unique case (phase)
            PH_P2N: begin
              p2n <= sum; phase <= PH_EN_PI; acc <= sum; k <= 2'd0;
            end
            PH_P2E: begin
              p2e <= sum; phase <= PH_EE_PI; acc <= sum; k <= 2'd0;
            end
            PH_PS2: begin
              ps2 <= sum; h <= 1'b0;
            end
            PH_M2: begin
              if (m2_neg) begin
                if (h) s <= s + CNT_W'(1);
                else h <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROOT: begin
        if (root_rsp.done) begin
          unique case (phase)
            PH_EN_PI: begin
              en_pi <= root_rsp.root[E_W-1:0]; phase <= PH_EN_K; acc <= p2n; k <= 2'd0;
            end
            PH_EN_K: begin
              en_k <= root_rsp.root[E_W-1:0]; s <= '0;
            end
            PH_EE_PI: begin
              ee_pi <= root_rsp.root[E_W-1:0]; phase <= PH_EE_K; acc <= p2e; k <= 2'd0;
            end
            PH_EE_K: begin
              ee_k <= root_rsp.root[E_W-1:0]; phase <= PH_PS2; acc <= '0; k <= 2'd0;
            end
            PH_M2: mass <= root_rsp.root;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        ent <= rdata;
        if (q_same) begin
          s <= s + CNT_W'(1);
        end else begin
          phase <= PH_P2E; acc <= '0; k <= 2'd0; h <= 1'b0;
        end
      end
      ST_HYP: begin
        if (!hyp_full) begin
          es    <= ES_W'(ea) + ES_W'(eb);
          phase <= PH_M2;
          acc   <= '0;
          k     <= 2'd0;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (in_win) begin
            pend_mass <= mass[MASS_W-1:0];
            pend_hyp  <= h;
            pend_slot <= s_ext[SLOT_OUT_W-1:0];
            n         <= n + RES_W'(1);
          end
          if (h) s <= s + CNT_W'(1);
          else h <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign results.valid        = out_valid;
  assign results.pair_mass    = out_mass;
  assign results.hypothesis   = out_hyp;
  assign results.partner_slot = out_slot;
  assign results.last_result  = out_last;

endmodule

`default_nettype wire

[sv/tmiw_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module tmiw_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  tmiw_pkg::root_req_t req,
  output tmiw_pkg::root_rsp_t rsp
);
  import tmiw_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic              done;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;

  assign rem_shift = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial     = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(ROOT_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad <= {rad[SQ_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

`default_nettype wire

[tb/tb_two_track_invariant_mass_window_core.sv]
`timescale 1ns / 1ps

module tb_two_track_invariant_mass_window_core;
  import tmiw_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_TRACKS;
  localparam int PAIR_CAP = 2 * (STORE_DEPTH - 1);
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 2500;
  localparam logic [22:0] MAX23 = 23'h7fffff;
  localparam logic [19:0] MAX20 = 20'hfffff;

  typedef struct {
    logic [MASS_W-1:0] mass;
    logic hyp;
    logic [SLOT_OUT_W-1:0] slot;
    logic last;
  } pair_t;

  class mass_scoreboard;
    longint signed st_x[STORE_DEPTH];
    longint signed st_y[STORE_DEPTH];
    longint signed st_z[STORE_DEPTH];
    logic [Q_W-1:0] st_q[STORE_DEPTH];
    int count;
    longint unsigned pion, kaon, wlo, whi;
    pair_t pending[$];
    int mismatches;
    int checked;
    int tracks;

    function new();
      count = 0;
      pion = PION_MASS_RST;
      kaon = KAON_MASS_RST;
      wlo = WINDOW_LOW_RST;
      whi = WINDOW_HIGH_RST;
      mismatches = 0;
      checked = 0;
      tracks = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned sq(longint signed a);
      longint unsigned u;
      u = (a < 0) ? longint'(-a) : a;
      return u * u;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PION_MASS: pion = val[PM_W-1:0];
        REG_KAON_MASS: kaon = val[PM_W-1:0];
        REG_WINDOW_LOW: wlo = val;
        REG_WINDOW_HIGH: whi = val;
        default: ;
      endcase
    endfunction

    function void note_track(longint signed x, longint signed y, longint signed z,
                             logic [Q_W-1:0] q, bit ee);
      longint unsigned p2n, en_pi, en_k, p2e, ee_pi, ee_k, psum2, ea, eb, es, es2, m;
      bit earlier_kaon;
      pair_t found[$];
      pair_t p;
      tracks++;
      p2n = sq(x) + sq(y) + sq(z);
      en_pi = isqrt(p2n + pion * pion);
      en_k = isqrt(p2n + kaon * kaon);
      for (int s = 0; s < count; s++) begin
        if (st_q[s] == q) continue;
        p2e = sq(st_x[s]) + sq(st_y[s]) + sq(st_z[s]);
        ee_pi = isqrt(p2e + pion * pion);
        ee_k = isqrt(p2e + kaon * kaon);
        psum2 = sq(st_x[s] + x) + sq(st_y[s] + y) + sq(st_z[s] + z);
        for (int h = 0; h < 2; h++) begin
          earlier_kaon = (h == 0) ? (st_q[s] == Q_NEG) : (st_q[s] == Q_POS);
          ea = earlier_kaon ? ee_k : ee_pi;
          eb = earlier_kaon ? en_pi : en_k;
          if (found.size() >= PAIR_CAP) break;
          es = ea + eb;
          es2 = es * es;
          if (es2 >= psum2) begin
            m = isqrt(es2 - psum2);
            if (m >= wlo && m <= whi) begin
              p.mass = m[MASS_W-1:0];
              p.hyp = h[0];
              p.slot = s[SLOT_OUT_W-1:0];
              p.last = 1'b0;
              found.insert(found.size(), p);
            end
          end
        end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending.insert(pending.size(), found[i]);
      if (count < STORE_DEPTH) begin
        st_x[count] = x;
        st_y[count] = y;
        st_z[count] = z;
        st_q[count] = q;
        count++;
      end
      if (ee) count = 0;
    endfunction

    function void check_result(pair_t got);
      pair_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mass %0d hyp %0d slot %0d last %0d",
                   got.mass, got.hyp, got.slot, got.last);
        return;
      end
      want = pending.pop_front();
      if (want.mass !== got.mass || want.hyp !== got.hyp || want.slot !== got.slot ||
          want.last !== got.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp mass %0d hyp %0d slot %0d last %0d, got %0d %0d %0d %0d",
                   want.mass, want.hyp, want.slot, want.last,
                   got.mass, got.hyp, got.slot, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int send_idle;
  int rcv_idle;
  int cycles;
  mass_scoreboard sb;

  tmiw_track_if trk();
  tmiw_result_if res();

  two_track_invariant_mass_window_core u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .tracks(trk),
    .results(res)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    sb = new();
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    pair_t got;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got.mass = res.pair_mass;
        got.hyp = res.hypothesis;
        got.slot = res.partner_slot;
        got.last = res.last_result;
        sb.check_result(got);
      end
      res.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_track(logic signed [MOM_W-1:0] x, logic signed [MOM_W-1:0] y,
                            logic signed [MOM_W-1:0] z, logic [Q_W-1:0] q, bit ee);
    while ($urandom_range(99) < send_idle) begin
      trk.valid <= 1'b0;
      @(posedge clk);
    end
    trk.valid <= 1'b1;
    trk.mom_x <= x;
    trk.mom_y <= y;
    trk.mom_z <= z;
    trk.track_charge <= q;
    trk.event_end <= ee;
    do @(posedge clk); while (!trk.ready);
    sb.note_track(x, y, z, q, ee);
  endtask

  task automatic drain();
    trk.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [CFG_W-1:0] pm, logic [CFG_W-1:0] km,
                         logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    drain();
    write_cfg(REG_PION_MASS, pm);
    write_cfg(REG_KAON_MASS, km);
    write_cfg(REG_WINDOW_LOW, lo);
    write_cfg(REG_WINDOW_HIGH, hi);
  endtask

  function automatic logic signed [MOM_W-1:0] rand_mom(bit wide);
    if (wide) return MOM_W'($urandom());
    return MOM_W'($signed($urandom_range(2000000)) - 1000000);
  endfunction

  function automatic logic [Q_W-1:0] rand_charge();
    int r;
    r = $urandom_range(99);
    if (r < 45) return Q_POS;
    if (r < 90) return Q_NEG;
    return Q_W'($urandom());
  endfunction

  task automatic run_events(int n_items);
    int sent;
    int len;
    bit noise;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        noise = ($urandom_range(99) < 10);
        send_track(rand_mom(noise), rand_mom(noise), rand_mom(noise), rand_charge(),
                   (i == len - 1) ? 1'b1 : (noise && $urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PION_MASS;
    cfg_data = '0;
    trk.valid = 1'b0;
    trk.mom_x = '0;
    trk.mom_y = '0;
    trk.mom_z = '0;
    trk.track_charge = '0;
    trk.event_end = 1'b0;
    res.ready = 1'b0;
    send_idle = 15;
    rcv_idle = 45;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wide window so directed pairs show up
    write_cfg(REG_WINDOW_LOW, '0);
    write_cfg(REG_WINDOW_HIGH, MAX23);
    send_track(26'sd0, 26'sd0, 26'sd0, Q_POS, 1'b1);
    send_track(26'sd33554431, 26'sd33554431, 26'sd33554431, Q_NEG, 1'b0);
    send_track(-26'sd33554432, -26'sd33554432, -26'sd33554432, Q_POS, 1'b0);
    send_track(26'sd0, 26'sd0, 26'sd0, 2'b00, 1'b0);
    send_track(26'sd1, -26'sd1, 26'sd1, 2'b10, 1'b0);
    send_track(26'sd1000, 26'sd0, 26'sd0, Q_POS, 1'b1);
    // overfill the store with one charge, then hit the result cap
    for (int i = 0; i < 18; i++)
      send_track(rand_mom(1'b0), rand_mom(1'b0), rand_mom(1'b0),
                 (i < 16) ? Q_NEG : Q_POS, i == 17);

    set_all(CFG_W'(PION_MASS_RST), CFG_W'(KAON_MASS_RST), WINDOW_LOW_RST, WINDOW_HIGH_RST);
    run_events(100);

    set_all(CFG_W'(MAX20), '0, '0, MAX23);
    run_events(30);

    set_all('0, CFG_W'(MAX20), MAX23, '0);
    run_events(20);

    set_all(CFG_W'(PION_MASS_RST), CFG_W'(KAON_MASS_RST), 23'd1500000, 23'd2300000);
    send_idle = 45;
    rcv_idle = 15;
    run_events(80);

    set_all(CFG_W'(PION_MASS_RST), CFG_W'(KAON_MASS_RST), WINDOW_LOW_RST, WINDOW_HIGH_RST);
    send_idle = 0;
    rcv_idle = 0;
    run_events(80);

    drain();
    $display("covered %0d tracks and %0d results over six register settings",
             sb.tracks, sb.checked);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
